// ===== rtl/sidta_pkg.sv =====
`default_nettype none

package sidta_pkg;

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_SKIP = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic pop;
	} dab_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sidta_dabble.sv =====
`default_nettype none

module sidta_dabble #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                   clk,
	input  wire sidta_pkg::dab_ctrl_t   ctrl,
	input  wire logic [VALUE_BITS-1:0]  load_mag,
	output logic [3:0]                  top_digit
);
	import sidta_pkg::*;

	localparam int NDIG  = (VALUE_BITS * 3) / 10 + 1;
	localparam int BCD_W = NDIG * 4;

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= load_mag;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bcd_q <= {adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end else if (ctrl.pop) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'b0000};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// signed integer to decimal ascii text
// input channel: value with value_valid / value_ready, one integer per beat,
//   taken only while the block is idle
// output channel: character and last_char with char_valid / char_ready, one
//   ascii character per beat, most significant first; a negative value starts
//   with '-', zero gives a single '0', last_char marks the final character
// sequence: after the input beat the shift-add-3 unit runs one magnitude bit
//   per cycle through the whole value, then drops one leading zero digit per
//   cycle, then sends one character per cycle while the receiver is ready;
//   the '-' of a negative value goes out before the first digit
// a new value is taken only after the last character of the current one has
//   been accepted
// a stalled receiver holds the current character in the output register and
//   the sequencer waits; value_ready comes back the cycle after the last beat
//   is taken
// reset clears the sequencer and the output valid; nothing is kept between
//   items
`default_nettype none

module signed_int_to_decimal_ascii_core #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         value_valid,
	output logic                              value_ready,
	input  wire logic signed [VALUE_BITS-1:0] value,
	output logic                              char_valid,
	input  wire logic                         char_ready,
	output logic [7:0]                        character,
	output logic                              last_char
);
	import sidta_pkg::*;

	localparam int NDIG  = (VALUE_BITS * 3) / 10 + 1;
	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam int DL_W  = $clog2(NDIG + 1);

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DL_W-1:0]       dig_left_q;
	logic                  neg_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic                  char_valid_q;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg;
	logic [3:0]            top_digit;
	logic                  out_free;
	logic                  skip_shift;
	logic                  emit_take;
	dab_ctrl_t             ctrl;

	assign raw = value;
	assign neg = raw[VALUE_BITS-1];
	assign mag = neg ? ('0 - raw) : raw;

	assign value_ready = (state_q == S_IDLE);
	assign out_free    = !char_valid_q || char_ready;
	assign skip_shift  = (state_q == S_SKIP) && (top_digit == 4'd0)
	                     && (dig_left_q > DL_W'(1));
	assign emit_take   = (state_q == S_EMIT) && out_free && (dig_left_q != '0);

	always_comb begin
		ctrl.load = value_valid && value_ready;
		ctrl.step = (state_q == S_CONV);
		ctrl.pop  = skip_shift || emit_take;
	end

	sidta_dabble #(
		.VALUE_BITS(VALUE_BITS)
	) u_dabble (
		.clk      (clk),
		.ctrl     (ctrl),
		.load_mag (mag),
		.top_digit(top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			dig_left_q   <= '0;
			char_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctrl.load) begin
						cnt_q   <= '0;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
						dig_left_q <= DL_W'(NDIG);
						state_q    <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (skip_shift) begin
						dig_left_q <= dig_left_q - DL_W'(1);
					end else begin
						if (neg_q) begin
							char_valid_q <= 1'b1;
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_take) begin
						char_valid_q <= 1'b1;
						dig_left_q   <= dig_left_q - DL_W'(1);
					end else if ((dig_left_q == '0) && out_free) begin
						char_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q      <= S_IDLE;
					char_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			neg_q <= neg;
		end
		if ((state_q == S_SKIP) && !skip_shift && neg_q) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (emit_take) begin
			char_q <= CHAR_ZERO + {4'b0000, top_digit};
			last_q <= (dig_left_q == DL_W'(1));
		end
	end

	assign char_valid = char_valid_q;
	assign character  = char_q;
	assign last_char  = last_q;

`ifndef ASSERT_OFF
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_ready && last_char |=> !char_valid)
		else $error("beat after last character");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		value_ready |-> !char_valid)
		else $error("input ready while a character is pending");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (character == CHAR_MINUS)
		|| ((character >= CHAR_ZERO) && (character <= CHAR_NINE)))
		else $error("character out of range");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (character == CHAR_MINUS) |-> !last_char)
		else $error("minus sign flagged as last");
`endif

endmodule

`default_nettype wire
